/* sv/hsfs_pkg.sv */
// Package for the H.264 SPS frame size parser: syntax step codes, status codes,
// command and status structs between controller and datapath, helper functions.
// No dependencies.
package hsfs_pkg;

  typedef enum logic [5:0] {
    ST_HDR = 6'd0, ST_PROFILE = 6'd1, ST_CONSTR = 6'd2, ST_SPSID = 6'd3,
    ST_CHROMA = 6'd4, ST_SEP = 6'd5, ST_DEPTHL = 6'd6, ST_DEPTHC = 6'd7,
    ST_BYPASS = 6'd8, ST_MATRIX = 6'd9, ST_LISTFLAG = 6'd10, ST_DELTA = 6'd11,
    ST_LOG2FN = 6'd12, ST_POC = 6'd13, ST_POCLSB = 6'd14, ST_DZERO = 6'd15,
    ST_OFFNR = 6'd16, ST_OFFTB = 6'd17, ST_NUMCYC = 6'd18, ST_OFFREF = 6'd19,
    ST_MAXREF = 6'd20, ST_GAPS = 6'd21, ST_WIDTH = 6'd22, ST_HEIGHT = 6'd23,
    ST_FRAMEONLY = 6'd24, ST_MBAFF = 6'd25, ST_DIRECT = 6'd26, ST_CROPFLAG = 6'd27,
    ST_CROPL = 6'd28, ST_CROPR = 6'd29, ST_CROPT = 6'd30, ST_CROPB = 6'd31,
    ST_DONE = 6'd32
  } syntax_step_t;

  localparam logic [2:0] STATUS_OK        = 3'd0;
  localparam logic [2:0] STATUS_SHORT     = 3'd1;
  localparam logic [2:0] STATUS_NOT_SPS   = 3'd2;
  localparam logic [2:0] STATUS_TRUNCATED = 3'd3;
  localparam logic [2:0] STATUS_RANGE     = 3'd4;

  localparam logic [7:0]  NAL_TYPE_SPS = 8'd7;
  localparam logic [16:0] LIM17 = 17'h1FFFF;

  typedef struct packed {
    logic       load;
    logic       feed;
    logic [2:0] bit_sel;
    logic       finish;
  } hsfs_cmd_t;

  typedef struct packed {
    logic skip;
  } hsfs_stat_t;

  function automatic logic high_profile(input logic [7:0] p);
    case (p) inside
      8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86, 8'd118,
      8'd128, 8'd138, 8'd139, 8'd134, 8'd135: high_profile = 1'b1;
      default: high_profile = 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] fixed_len(input syntax_step_t s);
    case (s) inside
      ST_HDR, ST_PROFILE: fixed_len = 5'd8;
      ST_CONSTR: fixed_len = 5'd16;
      ST_SEP, ST_BYPASS, ST_MATRIX, ST_LISTFLAG, ST_DZERO, ST_GAPS,
      ST_FRAMEONLY, ST_MBAFF, ST_DIRECT, ST_CROPFLAG: fixed_len = 5'd1;
      default: fixed_len = 5'd0;
    endcase
  endfunction

endpackage

/* sv/hsfs_in_if.sv */
// Input channel: one raw NAL byte per item with a last flag.
// No dependencies.
interface hsfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

/* sv/hsfs_out_if.sv */
// Output channel: cropped frame size and parse status per item.
// No dependencies.
interface hsfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_width;
  logic [15:0] frame_height;
  logic [2:0]  parse_status;
  modport source (output valid, output frame_width, output frame_height,
                  output parse_status, input ready);
  modport sink (input valid, input frame_width, input frame_height,
                input parse_status, output ready);
endinterface

/* sv/hsfs_datapath.sv */
// Datapath: byte intake, emulation-prevention drop, bit-serial SPS syntax walk
// with u(n)/ue(v)/se(v) readers, and final size computation. Uses hsfs_pkg.
module hsfs_datapath import hsfs_pkg::*; #(
  parameter int MIN_NAL_BYTES    = 10,
  parameter int MAX_GOLOMB_ZEROS = 31,
  parameter int MAX_NAL_BYTES    = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  hsfs_cmd_t   cmd,
  output hsfs_stat_t  stat,
  input  logic [7:0]  data_byte,
  output logic [15:0] frame_width,
  output logic [15:0] frame_height,
  output logic [2:0]  parse_status
);

  logic [7:0]   byte_reg;
  logic [7:0]   byte_count;
  logic [1:0]   zero_run;
  syntax_step_t syntax_step, syntax_step_next;
  logic         golomb_phase, golomb_phase_next;
  logic [5:0]   golomb_zeros, golomb_zeros_next;
  logic [31:0]  field_accum, field_accum_next;
  logic [7:0]   profile_code, profile_code_next;
  logic [1:0]   chroma_format, chroma_format_next;
  logic [3:0]   list_index, list_index_next;
  logic [6:0]   coef_index, coef_index_next;
  logic [7:0]   last_scale, last_scale_next;
  logic [7:0]   next_scale, next_scale_next;
  logic [1:0]   poc_type, poc_type_next;
  logic [7:0]   ref_cycle_left, ref_cycle_left_next;
  logic [16:0]  width_mbs, width_mbs_next;
  logic [16:0]  height_units, height_units_next;
  logic         frame_only_flag, frame_only_flag_next;
  logic [16:0]  crop_horizontal, crop_horizontal_next;
  logic [16:0]  crop_vertical, crop_vertical_next;
  logic [2:0]   error_code, error_code_next;

  assign stat.skip = (zero_run == 2'd2) && (data_byte == 8'd3);

  // Bit-serial syntax walk
  logic        b, fin, eflag;
  logic [2:0]  ecode;
  logic [4:0]  flen;
  logic [15:0] acc16;
  logic [31:0] v;
  logic [32:0] v_inc, sum33;
  logic [3:0]  li1;
  logic [3:0]  list_limit;
  logic [7:0]  mag8, d8, ns;
  logic [6:0]  ci1, list_size;
  syntax_step_t list_step;

  always_comb begin
    syntax_step_next     = syntax_step;
    golomb_phase_next    = golomb_phase;
    golomb_zeros_next    = golomb_zeros;
    field_accum_next     = field_accum;
    profile_code_next    = profile_code;
    chroma_format_next   = chroma_format;
    list_index_next      = list_index;
    coef_index_next      = coef_index;
    last_scale_next      = last_scale;
    next_scale_next      = next_scale;
    poc_type_next        = poc_type;
    ref_cycle_left_next  = ref_cycle_left;
    width_mbs_next       = width_mbs;
    height_units_next    = height_units;
    frame_only_flag_next = frame_only_flag;
    crop_horizontal_next = crop_horizontal;
    crop_vertical_next   = crop_vertical;
    eflag = 1'b0;
    ecode = STATUS_RANGE;
    fin   = 1'b0;
    v     = '0;
    b     = byte_reg[3'd7 - cmd.bit_sel];
    flen  = fixed_len(syntax_step);
    acc16 = {field_accum[14:0], b};
    li1        = list_index + 4'd1;
    list_limit = (chroma_format == 2'd3) ? 4'd12 : 4'd8;
    list_step  = (li1 < list_limit) ? ST_LISTFLAG : ST_LOG2FN;
    mag8  = '0;
    d8    = '0;
    ns    = '0;
    ci1   = '0;
    list_size = '0;
    v_inc = '0;
    sum33 = '0;

    if (cmd.feed && (syntax_step != ST_DONE)) begin
      if (flen != 5'd0) begin
        field_accum_next  = {16'd0, acc16};
        golomb_zeros_next = golomb_zeros + 6'd1;
        if (golomb_zeros_next >= {1'b0, flen}) begin
          fin = 1'b1;
          v   = {16'd0, acc16};
        end
      end else if (!golomb_phase) begin
        if (!b) begin
          if (golomb_zeros < 6'(MAX_GOLOMB_ZEROS)) golomb_zeros_next = golomb_zeros + 6'd1;
          else eflag = 1'b1;
        end else begin
          field_accum_next = 32'd1;
          if (golomb_zeros == 6'd0) fin = 1'b1;
          else golomb_phase_next = 1'b1;
        end
      end else begin
        field_accum_next  = {field_accum[30:0], b};
        golomb_zeros_next = golomb_zeros - 6'd1;
        if (golomb_zeros_next == 6'd0) begin
          fin = 1'b1;
          v   = field_accum_next - 32'd1;
        end
      end

      v_inc = {1'b0, v} + 33'd1;

      if (fin) begin
        field_accum_next  = '0;
        golomb_zeros_next = '0;
        golomb_phase_next = 1'b0;
        case (syntax_step)
          ST_HDR: begin
            if (v[4:0] != NAL_TYPE_SPS[4:0]) begin
              eflag = 1'b1;
              ecode = STATUS_NOT_SPS;
              syntax_step_next = ST_DONE;
            end else syntax_step_next = ST_PROFILE;
          end
          ST_PROFILE: begin
            profile_code_next = v[7:0];
            syntax_step_next  = ST_CONSTR;
          end
          ST_CONSTR: syntax_step_next = ST_SPSID;
          ST_SPSID: syntax_step_next = high_profile(profile_code) ? ST_CHROMA : ST_LOG2FN;
          ST_CHROMA: begin
            if (v > 32'd3) begin
              eflag = 1'b1;
              chroma_format_next = 2'd3;
            end else chroma_format_next = v[1:0];
            syntax_step_next = (chroma_format_next == 2'd3) ? ST_SEP : ST_DEPTHL;
          end
          ST_SEP:    syntax_step_next = ST_DEPTHL;
          ST_DEPTHL: syntax_step_next = ST_DEPTHC;
          ST_DEPTHC: syntax_step_next = ST_BYPASS;
          ST_BYPASS: syntax_step_next = ST_MATRIX;
          ST_MATRIX: begin
            if (v[0]) begin
              list_index_next  = '0;
              syntax_step_next = ST_LISTFLAG;
            end else syntax_step_next = ST_LOG2FN;
          end
          ST_LISTFLAG: begin
            if (v[0]) begin
              last_scale_next  = 8'd8;
              next_scale_next  = 8'd8;
              coef_index_next  = '0;
              syntax_step_next = ST_DELTA;
            end else begin
              list_index_next  = li1;
              syntax_step_next = list_step;
            end
          end
          ST_DELTA: begin
            mag8 = v[8:1] + {7'd0, v[0]};
            d8   = v[0] ? mag8 : (8'd0 - mag8);
            ns   = last_scale + d8;
            next_scale_next = ns;
            if (ns != 8'd0) last_scale_next = ns;
            ci1 = coef_index + 7'd1;
            coef_index_next = ci1;
            list_size = (list_index < 4'd6) ? 7'd16 : 7'd64;
            if ((ns == 8'd0) || (ci1 >= list_size)) begin
              list_index_next  = li1;
              syntax_step_next = list_step;
            end
          end
          ST_LOG2FN: syntax_step_next = ST_POC;
          ST_POC: begin
            if (v > 32'd2) eflag = 1'b1;
            poc_type_next = (v > 32'd3) ? 2'd3 : v[1:0];
            if (v == 32'd0) syntax_step_next = ST_POCLSB;
            else if (v == 32'd1) syntax_step_next = ST_DZERO;
            else syntax_step_next = ST_MAXREF;
          end
          ST_POCLSB: syntax_step_next = ST_MAXREF;
          ST_DZERO:  syntax_step_next = ST_OFFNR;
          ST_OFFNR:  syntax_step_next = ST_OFFTB;
          ST_OFFTB:  syntax_step_next = ST_NUMCYC;
          ST_NUMCYC: begin
            if (v > 32'd255) begin
              eflag = 1'b1;
              ref_cycle_left_next = 8'd255;
            end else ref_cycle_left_next = v[7:0];
            syntax_step_next = (ref_cycle_left_next != 8'd0) ? ST_OFFREF : ST_MAXREF;
          end
          ST_OFFREF: begin
            if (ref_cycle_left != 8'd0) ref_cycle_left_next = ref_cycle_left - 8'd1;
            if (ref_cycle_left_next == 8'd0) syntax_step_next = ST_MAXREF;
          end
          ST_MAXREF: syntax_step_next = ST_GAPS;
          ST_GAPS:   syntax_step_next = ST_WIDTH;
          ST_WIDTH: begin
            if (v_inc > {16'd0, LIM17}) begin
              eflag = 1'b1;
              width_mbs_next = LIM17;
            end else width_mbs_next = v_inc[16:0];
            syntax_step_next = ST_HEIGHT;
          end
          ST_HEIGHT: begin
            if (v_inc > {16'd0, LIM17}) begin
              eflag = 1'b1;
              height_units_next = LIM17;
            end else height_units_next = v_inc[16:0];
            syntax_step_next = ST_FRAMEONLY;
          end
          ST_FRAMEONLY: begin
            frame_only_flag_next = v[0];
            syntax_step_next = v[0] ? ST_DIRECT : ST_MBAFF;
          end
          ST_MBAFF:    syntax_step_next = ST_DIRECT;
          ST_DIRECT:   syntax_step_next = ST_CROPFLAG;
          ST_CROPFLAG: syntax_step_next = v[0] ? ST_CROPL : ST_DONE;
          ST_CROPL, ST_CROPT: begin
            if ({1'b0, v} > {16'd0, LIM17}) begin
              eflag = 1'b1;
              sum33 = {16'd0, LIM17};
            end else sum33 = {1'b0, v};
            if (syntax_step == ST_CROPL) begin
              crop_horizontal_next = sum33[16:0];
              syntax_step_next = ST_CROPR;
            end else begin
              crop_vertical_next = sum33[16:0];
              syntax_step_next = ST_CROPB;
            end
          end
          ST_CROPR: begin
            sum33 = {16'd0, crop_horizontal} + {1'b0, v};
            if (sum33 > {16'd0, LIM17}) begin
              eflag = 1'b1;
              crop_horizontal_next = LIM17;
            end else crop_horizontal_next = sum33[16:0];
            syntax_step_next = ST_CROPT;
          end
          ST_CROPB: begin
            sum33 = {16'd0, crop_vertical} + {1'b0, v};
            if (sum33 > {16'd0, LIM17}) begin
              eflag = 1'b1;
              crop_vertical_next = LIM17;
            end else crop_vertical_next = sum33[16:0];
            syntax_step_next = ST_DONE;
          end
          default: syntax_step_next = ST_DONE;
        endcase
      end
    end
    error_code_next = (eflag && (error_code == STATUS_OK)) ? ecode : error_code;
  end

  // Final size: width 16*w - 2*ch, height (16*h - 2*cv) doubled for field coding
  logic signed [24:0] fw, fh, h_raw;
  logic [2:0] final_status;

  always_comb begin
    fw    = $signed({4'd0, width_mbs, 4'd0}) - $signed({7'd0, crop_horizontal, 1'b0});
    h_raw = $signed({4'd0, height_units, 4'd0}) - $signed({7'd0, crop_vertical, 1'b0});
    fh    = frame_only_flag ? h_raw : (h_raw <<< 1);
    if (byte_count < 8'(MIN_NAL_BYTES)) final_status = STATUS_SHORT;
    else if (error_code != STATUS_OK) final_status = error_code;
    else if (syntax_step != ST_DONE) final_status = STATUS_TRUNCATED;
    else if ((fw < 0) || (fw > 25'sd65535) || (fh < 0) || (fh > 25'sd65535))
      final_status = STATUS_RANGE;
    else final_status = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      parse_status <= final_status;
      frame_width  <= (final_status == STATUS_OK) ? fw[15:0] : 16'd0;
      frame_height <= (final_status == STATUS_OK) ? fh[15:0] : 16'd0;
    end
    if (cmd.load) byte_reg <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      byte_count      <= '0;
      zero_run        <= '0;
      syntax_step     <= ST_HDR;
      golomb_phase    <= 1'b0;
      golomb_zeros    <= '0;
      field_accum     <= '0;
      profile_code    <= '0;
      chroma_format   <= 2'd1;
      list_index      <= '0;
      coef_index      <= '0;
      last_scale      <= 8'd8;
      next_scale      <= 8'd8;
      poc_type        <= '0;
      ref_cycle_left  <= '0;
      width_mbs       <= '0;
      height_units    <= '0;
      frame_only_flag <= 1'b1;
      crop_horizontal <= '0;
      crop_vertical   <= '0;
      error_code      <= STATUS_OK;
    end else begin
      if (cmd.load) begin
        if (byte_count < 8'(MAX_NAL_BYTES)) byte_count <= byte_count + 8'd1;
        if (stat.skip) zero_run <= '0;
        else if (data_byte == 8'd0) zero_run <= (zero_run < 2'd2) ? zero_run + 2'd1 : 2'd2;
        else zero_run <= '0;
      end
      syntax_step     <= syntax_step_next;
      golomb_phase    <= golomb_phase_next;
      golomb_zeros    <= golomb_zeros_next;
      field_accum     <= field_accum_next;
      profile_code    <= profile_code_next;
      chroma_format   <= chroma_format_next;
      list_index      <= list_index_next;
      coef_index      <= coef_index_next;
      last_scale      <= last_scale_next;
      next_scale      <= next_scale_next;
      poc_type        <= poc_type_next;
      ref_cycle_left  <= ref_cycle_left_next;
      width_mbs       <= width_mbs_next;
      height_units    <= height_units_next;
      frame_only_flag <= frame_only_flag_next;
      crop_horizontal <= crop_horizontal_next;
      crop_vertical   <= crop_vertical_next;
      error_code      <= error_code_next;
    end
  end

endmodule

/* sv/hsfs_controller.sv */
// Controller: sequences byte intake, the bit walk over each byte, the final
// computation and result delivery. Uses hsfs_pkg.
module hsfs_controller import hsfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  hsfs_stat_t stat,
  output hsfs_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_BITS  = 4'b0010,
    S_FINAL = 4'b0100,
    S_OUT   = 4'b1000
  } ctl_state_t;

  ctl_state_t state, state_next;
  logic [2:0] bit_cnt;
  logic       last_flag;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.feed    = (state == S_BITS);
    cmd.bit_sel = bit_cnt;
    cmd.finish  = (state == S_FINAL);
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (!stat.skip) state_next = S_BITS;
          else if (in_last) state_next = S_FINAL;
        end
      end
      S_BITS: begin
        if (bit_cnt == 3'd7) state_next = last_flag ? S_FINAL : S_IDLE;
      end
      S_FINAL: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) bit_cnt <= '0;
      else if (cmd.feed) bit_cnt <= bit_cnt + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) last_flag <= in_last;
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while result pending");
  a_fin: assert property (@(posedge clk) disable iff (rst) cmd.finish |=> out_valid)
    else $error("result not presented after finish");
  a_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !stat.skip) |=> cmd.feed)
    else $error("bit walk did not start after byte load");
`endif

endmodule

/* sv/h264_sps_frame_size_parser.sv */
// H.264 SPS frame size parser top level: one byte item in, one size item per NAL.
// Each byte is taken in S_IDLE, then walked bit by bit in S_BITS (a dropped
// emulation-prevention byte skips it); the bit-serial syntax walker sets the byte rate.
// After the final byte, S_FINAL computes the size; S_OUT holds the result until taken.
// Reset: synchronous, active high; clears the controller and all parse state.
// Depends on hsfs_pkg, hsfs_in_if, hsfs_out_if, hsfs_controller, hsfs_datapath.
module h264_sps_frame_size_parser import hsfs_pkg::*; #(
  parameter int MIN_NAL_BYTES    = 10,
  parameter int MAX_GOLOMB_ZEROS = 31,
  parameter int MAX_NAL_BYTES    = 255
) (
  input logic        clk,
  input logic        rst,
  hsfs_in_if.sink    nal,
  hsfs_out_if.source size
);

  hsfs_cmd_t  cmd;
  hsfs_stat_t stat;

  // Controller: hold the input while a byte walks or a result waits
  hsfs_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nal.valid),
    .in_last   (nal.last_byte),
    .in_ready  (nal.ready),
    .out_valid (size.valid),
    .out_ready (size.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: drop emulation bytes, advance the syntax walk a bit per cycle while a byte walks
  hsfs_datapath #(
    .MIN_NAL_BYTES    (MIN_NAL_BYTES),
    .MAX_GOLOMB_ZEROS (MAX_GOLOMB_ZEROS),
    .MAX_NAL_BYTES    (MAX_NAL_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (nal.data_byte),
    .frame_width  (size.frame_width),
    .frame_height (size.frame_height),
    .parse_status (size.parse_status)
  );

endmodule
